// File: hw/rtl/successor_list_symbol_decoder_assert.svh
// Assertion macros shared by the successor list symbol decoder modules
`ifndef SUCCESSOR_LIST_SYMBOL_DECODER_ASSERT_SVH
`define SUCCESSOR_LIST_SYMBOL_DECODER_ASSERT_SVH

// expression holds at every edge out of reset
`define SLSD_ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SLSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define SLSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/slsd_pkg.sv
// Types shared by the successor list symbol decoder
package slsd_pkg;

	typedef struct packed {
		logic [7:0] cipher_byte;
		logic       message_start;
	} slsd_in_word_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic       was_new;
	} slsd_out_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic reduce_grp;
		logic reduce_all;
		logic update;
	} slsd_cmd_t;

	localparam int GRP_SIZE = 16;

endpackage

// File: hw/rtl/slsd_stream_if.sv
// Valid/ready stream channel carrying one word per handshake
interface slsd_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/slsd_ctrl.sv
// Sequencing controller of the successor list symbol decoder
`include "successor_list_symbol_decoder_assert.svh"

module slsd_ctrl import slsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output slsd_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_GRP,
		S_ALL,
		S_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = in_valid && (state_q == S_IDLE);
		cmd.reduce_grp = (state_q == S_GRP);
		cmd.reduce_all = (state_q == S_ALL);
		cmd.update     = (state_q == S_UPD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_GRP;
				end
				S_GRP: state_q <= S_ALL;
				S_ALL: state_q <= S_UPD;
				S_UPD: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.update)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`SLSD_ASSERT_NEXT(a_load_starts, clk, arst_n, cmd.load, state_q == S_GRP, "accepted word did not start reduction")
	`SLSD_ASSERT_NEXT(a_update_shows, clk, arst_n, cmd.update, out_valid_q, "updated word not presented")
	`SLSD_ASSERT_NEXT(a_upd_waits, clk, arst_n, (state_q == S_UPD) && out_valid_q && !out_ready, state_q == S_UPD, "finished word dropped while output full")

endmodule

// File: hw/rtl/slsd_datapath.sv
// Symbol list cells, match reduction tree and output register
`include "successor_list_symbol_decoder_assert.svh"

module slsd_datapath import slsd_pkg::*; #(
	parameter int LIST_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  slsd_cmd_t      cmd,
	input  slsd_in_word_t  in_word,
	output slsd_out_word_t out_word
);

	localparam int LENW = $clog2(LIST_DEPTH + 1);
	localparam int IDXW = $clog2(LIST_DEPTH);
	localparam int NGRP = (LIST_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
	localparam logic [LENW-1:0] DEPTH_L = LENW'(LIST_DEPTH);

	logic [7:0]            cell_q [LIST_DEPTH];
	logic [LENW-1:0]       len_q;
	logic [LENW-1:0]       len_eff;
	logic [LIST_DEPTH-1:0] hit;

	logic [7:0]            sym_s1;
	logic [LIST_DEPTH-1:0] match_s1;

	logic [NGRP-1:0]       gfound_d;
	logic [IDXW-1:0]       gpos_d [NGRP];
	logic [7:0]            gval_d [NGRP];
	logic [NGRP-1:0]       gfound_s2;
	logic [IDXW-1:0]       gpos_s2 [NGRP];
	logic [7:0]            gval_s2 [NGRP];

	logic                  found_d;
	logic [IDXW-1:0]       pos_d;
	logic [7:0]            valnx_d;
	logic                  found_s3;
	logic [IDXW-1:0]       pos_s3;
	logic [7:0]            valnx_s3;

	logic                  last_hit;
	logic [7:0]            succ_val;
	slsd_out_word_t        out_q;

	assign len_eff = in_word.message_start ? '0 : len_q;

	// successor of the last entry wraps to the head
	assign last_hit = found_s3 && ((LENW'(pos_s3) + LENW'(1)) == len_q);
	assign succ_val = last_hit ? cell_q[0] : valnx_s3;

	for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
		localparam logic [LENW-1:0] K_L   = LENW'(k);
		localparam logic [LENW-1:0] K_P1  = LENW'(k + 1);
		logic [7:0] nb;

		if (k < LIST_DEPTH - 1) begin : g_nb
			assign nb = cell_q[k + 1];
		end else begin : g_end
			assign nb = cell_q[k];
		end

		assign hit[k] = (K_L < len_eff) && (cell_q[k] == in_word.cipher_byte);

		always_ff @(posedge clk) begin
			if (cmd.update) begin
				if (found_s3) begin
					if (K_P1 == len_q)
						cell_q[k] <= succ_val;
					else if ((K_P1 < len_q) && (last_hit || (K_L > LENW'(pos_s3))))
						cell_q[k] <= nb;
				end else if (K_L == len_q) begin
					cell_q[k] <= sym_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			match_s1 <= '0;
		end else if (cmd.load) begin
			len_q    <= len_eff;
			match_s1 <= hit;
		end else if (cmd.update && !found_s3 && (len_q < DEPTH_L)) begin
			len_q    <= len_q + LENW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			sym_s1 <= in_word.cipher_byte;
	end

	// first level: per group of cells
	always_comb begin
		int idx;
		for (int g = 0; g < NGRP; g++) begin
			gfound_d[g] = 1'b0;
			gpos_d[g]   = '0;
			gval_d[g]   = '0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				idx = g * GRP_SIZE + j;
				if (idx < LIST_DEPTH) begin
					if (match_s1[idx]) begin
						gfound_d[g] = 1'b1;
						gpos_d[g]   = gpos_d[g] | IDXW'(idx);
					end
					if ((idx > 0) && match_s1[idx - 1])
						gval_d[g] = gval_d[g] | cell_q[idx];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reduce_grp) begin
			gfound_s2 <= gfound_d;
			gpos_s2   <= gpos_d;
			gval_s2   <= gval_d;
		end
	end

	// second level: across groups
	always_comb begin
		found_d = 1'b0;
		pos_d   = '0;
		valnx_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			found_d = found_d | gfound_s2[g];
			pos_d   = pos_d | gpos_s2[g];
			valnx_d = valnx_d | gval_s2[g];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reduce_all) begin
			found_s3 <= found_d;
			pos_s3   <= pos_d;
			valnx_s3 <= valnx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_q.plain_byte <= found_s3 ? succ_val : sym_s1;
			out_q.was_new    <= !found_s3;
		end
	end

	assign out_word = out_q;

	`SLSD_ASSERT_HOLDS(a_match_unique, clk, arst_n, $onehot0(match_s1), "symbol present more than once")
	`SLSD_ASSERT_HOLDS(a_len_bound, clk, arst_n, len_q <= DEPTH_L, "list length beyond depth")
	`SLSD_ASSERT_SAME(a_pos_in_list, clk, arst_n, cmd.update && found_s3, LENW'(pos_s3) < len_q, "match position outside list")

endmodule

// File: hw/rtl/successor_list_symbol_decoder.sv
// Successor list symbol decoder top level
//
// in_ch carries one cipher byte per word with a message_start flag; a set
// flag empties the symbol list before that byte is looked up. out_ch returns
// one word per input word, in order: the decoded byte and was_new.
// A word is match-compared at accept, then passes two registered reduction
// levels and the list update before it is presented on out_ch. in_ch.ready
// is high only while the controller is idle, so no word is taken before the
// last leaves its update step; the shared match/reduction path is the limit.
// Reset leaves the list empty and the block ready at once; no clearing pass.
// When the receiver stalls, the finished word waits in the output register
// while the next word is accepted and reduced; that word then holds in its
// update step, list untouched, until the output register is free.
// List length is set by LIST_DEPTH (2 to 256 entries).
module successor_list_symbol_decoder import slsd_pkg::*; #(
	parameter int LIST_DEPTH = 256
) (
	input logic           clk,
	input logic           arst_n,
	slsd_stream_if.sink   in_ch,
	slsd_stream_if.source out_ch
);

	slsd_cmd_t      cmd;
	slsd_in_word_t  in_word;
	slsd_out_word_t out_word;
	logic           in_ready;
	logic           out_valid;

	assign in_word        = in_ch.payload;
	assign in_ch.ready    = in_ready;
	assign out_ch.valid   = out_valid;
	assign out_ch.payload = out_word;

	slsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	slsd_datapath #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_word  (in_word),
		.out_word (out_word)
	);

endmodule

// File: verif/successor_list_symbol_decoder_test.sv
// Self-checking testbench for the successor list symbol decoder
module successor_list_symbol_decoder_test;
	import slsd_pkg::*;

	localparam int LIST_DEPTH = 256;
	localparam int RANDOM_WORDS = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PERCENT = 16;
	localparam int REPORT_LIMIT = 10;

	logic clk;
	logic arst_n;

	slsd_stream_if #(.word_t(slsd_in_word_t)) in_ch ();
	slsd_stream_if #(.word_t(slsd_out_word_t)) out_ch ();

	successor_list_symbol_decoder #(
		.LIST_DEPTH(LIST_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [7:0]     sym_list [LIST_DEPTH];
	int             sym_count;
	slsd_out_word_t expected_words [$];
	slsd_out_word_t exp_word;
	int             mismatch_count;
	int             cycle_count;
	bit             no_idle;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// decoded word for one cipher byte; updates the local copy of the list
	function automatic slsd_out_word_t decode_symbol(slsd_in_word_t w);
		slsd_out_word_t r;
		int             pos;
		int             succ;
		logic [7:0]     val;
		if (w.message_start)
			sym_count = 0;
		pos = -1;
		for (int k = 0; k < sym_count; k++)
			if (pos < 0 && sym_list[k] == w.cipher_byte)
				pos = k;
		if (pos < 0) begin
			if (sym_count < LIST_DEPTH) begin
				sym_list[sym_count] = w.cipher_byte;
				sym_count++;
			end
			r.plain_byte = w.cipher_byte;
			r.was_new = 1'b1;
		end else begin
			succ = (pos + 1 == sym_count) ? 0 : pos + 1;
			val = sym_list[succ];
			for (int k = succ; k + 1 < sym_count; k++)
				sym_list[k] = sym_list[k + 1];
			sym_list[sym_count - 1] = val;
			r.plain_byte = val;
			r.was_new = 1'b0;
		end
		return r;
	endfunction

	function automatic void note_mismatch(string what, int exp_val, int act_val);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch %s: expected %0h, got %0h", what, exp_val, act_val);
	endfunction

	task automatic send_word(logic [7:0] cipher, logic start);
		slsd_in_word_t w;
		w.cipher_byte = cipher;
		w.message_start = start;
		@(negedge clk);
		if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= w;
		do
			@(posedge clk);
		while (!in_ch.ready);
		expected_words.push_back(decode_symbol(w));
	endtask

	task automatic finish_burst();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		wait (expected_words.size() == 0);
	endtask

	task automatic test_directed();
		send_word(8'h01, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h7F, 1'b0);
		send_word(8'h01, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h55, 1'b0);
		send_word(8'hAA, 1'b0);
		send_word(8'hAA, 1'b0);
		// cleared list, one entry matching itself
		send_word(8'h42, 1'b1);
		send_word(8'h42, 1'b0);
		send_word(8'h42, 1'b0);
		send_word(8'h01, 1'b1);
		send_word(8'h01, 1'b0);
		send_word(8'h02, 1'b0);
		send_word(8'h02, 1'b0);
		send_word(8'h01, 1'b0);
		send_word(8'h00, 1'b1);
		send_word(8'h00, 1'b0);
		finish_burst();
	endtask

	// every byte value in one message, list filled to its depth
	task automatic test_list_full();
		logic [7:0] perm [256];
		int         j;
		logic [7:0] tmp;
		for (int i = 0; i < 256; i++)
			perm[i] = i[7:0];
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		for (int i = 0; i < 256; i++)
			send_word(perm[i], i == 0);
		for (int i = 0; i < 24; i++)
			send_word(8'($urandom_range(0, 255)), 1'b0);
		finish_burst();
	endtask

	task automatic test_random_messages();
		logic [7:0] pool [16];
		int         pool_size;
		int         msg_len;
		int         sent;
		logic [7:0] cipher;
		logic       start;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			no_idle = (sent >= 100 && sent < 230);
			pool_size = $urandom_range(1, 16);
			for (int i = 0; i < pool_size; i++)
				pool[i] = 8'($urandom_range(0, 255));
			msg_len = $urandom_range(1, 48);
			for (int i = 0; i < msg_len; i++) begin
				start = (i == 0);
				if (i == 0 && $urandom_range(99) < 10)
					start = 1'b0;
				if ($urandom_range(99) < 8) begin
					cipher = 8'($urandom_range(0, 255));
					start = start | ($urandom_range(99) < 25);
				end else begin
					cipher = pool[$urandom_range(0, pool_size - 1)];
				end
				send_word(cipher, start);
				sent++;
			end
		end
		no_idle = 1'b0;
		finish_burst();
	endtask

	always @(negedge clk)
		out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_words.size() == 0) begin
				note_mismatch("unexpected word", 0, int'(out_ch.payload));
			end else begin
				exp_word = expected_words.pop_front();
				if (out_ch.payload.plain_byte !== exp_word.plain_byte)
					note_mismatch("plain_byte", int'(exp_word.plain_byte),
						int'(out_ch.payload.plain_byte));
				if (out_ch.payload.was_new !== exp_word.was_new)
					note_mismatch("was_new", int'(exp_word.was_new),
						int'(out_ch.payload.was_new));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		sym_count = 0;
		mismatch_count = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_list_full();
		test_random_messages();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_words.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
